>>> hdl/assert_macros.svh
// assertion macros used by the checker file
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property that must hold at every clock edge outside reset
`define ASSERT_ALWAYS(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// antecedent implies consequent in the next cycle
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

>>> hdl/sha512_pkg.sv
// package for the sha-512/384 core: types, round constants, initial values
// no dependencies
package sha512_pkg;

   typedef logic [63:0] word_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_PAD,
      ST_LEN,
      ST_ROUND,
      ST_FOLD,
      ST_OUT
   } state_type;

   localparam int unsigned ROUNDS = 80;
   localparam int unsigned BLOCK_WORDS = 16;
   localparam logic [3:0] LENGTH_SLOT = 4'd14;

   function automatic word_type round_const(input logic [6:0] idx);
      word_type k [0:79];
      k = '{
         64'h428a2f98d728ae22, 64'h7137449123ef65cd, 64'hb5c0fbcfec4d3b2f, 64'he9b5dba58189dbbc,
         64'h3956c25bf348b538, 64'h59f111f1b605d019, 64'h923f82a4af194f9b, 64'hab1c5ed5da6d8118,
         64'hd807aa98a3030242, 64'h12835b0145706fbe, 64'h243185be4ee4b28c, 64'h550c7dc3d5ffb4e2,
         64'h72be5d74f27b896f, 64'h80deb1fe3b1696b1, 64'h9bdc06a725c71235, 64'hc19bf174cf692694,
         64'he49b69c19ef14ad2, 64'hefbe4786384f25e3, 64'h0fc19dc68b8cd5b5, 64'h240ca1cc77ac9c65,
         64'h2de92c6f592b0275, 64'h4a7484aa6ea6e483, 64'h5cb0a9dcbd41fbd4, 64'h76f988da831153b5,
         64'h983e5152ee66dfab, 64'ha831c66d2db43210, 64'hb00327c898fb213f, 64'hbf597fc7beef0ee4,
         64'hc6e00bf33da88fc2, 64'hd5a79147930aa725, 64'h06ca6351e003826f, 64'h142929670a0e6e70,
         64'h27b70a8546d22ffc, 64'h2e1b21385c26c926, 64'h4d2c6dfc5ac42aed, 64'h53380d139d95b3df,
         64'h650a73548baf63de, 64'h766a0abb3c77b2a8, 64'h81c2c92e47edaee6, 64'h92722c851482353b,
         64'ha2bfe8a14cf10364, 64'ha81a664bbc423001, 64'hc24b8b70d0f89791, 64'hc76c51a30654be30,
         64'hd192e819d6ef5218, 64'hd69906245565a910, 64'hf40e35855771202a, 64'h106aa07032bbd1b8,
         64'h19a4c116b8d2d0c8, 64'h1e376c085141ab53, 64'h2748774cdf8eeb99, 64'h34b0bcb5e19b48a8,
         64'h391c0cb3c5c95a63, 64'h4ed8aa4ae3418acb, 64'h5b9cca4f7763e373, 64'h682e6ff3d6b2b8a3,
         64'h748f82ee5defb2fc, 64'h78a5636f43172f60, 64'h84c87814a1f0ab72, 64'h8cc702081a6439ec,
         64'h90befffa23631e28, 64'ha4506cebde82bde9, 64'hbef9a3f7b2c67915, 64'hc67178f2e372532b,
         64'hca273eceea26619c, 64'hd186b8c721c0c207, 64'heada7dd6cde0eb1e, 64'hf57d4f7fee6ed178,
         64'h06f067aa72176fba, 64'h0a637dc5a2c898a6, 64'h113f9804bef90dae, 64'h1b710b35131c471b,
         64'h28db77f523047d84, 64'h32caab7b40c72493, 64'h3c9ebe0a15c9bebc, 64'h431d67c49c100d4c,
         64'h4cc5d4becb3e42b6, 64'h597f299cfc657e2a, 64'h5fcb6fab3ad6faec, 64'h6c44198c4a475817
      };
      return k[idx];
   endfunction

   function automatic word_type init_value(input logic mode, input logic [2:0] idx);
      word_type h512 [0:7];
      word_type h384 [0:7];
      h512 = '{64'h6a09e667f3bcc908, 64'hbb67ae8584caa73b, 64'h3c6ef372fe94f82b,
               64'ha54ff53a5f1d36f1, 64'h510e527fade682d1, 64'h9b05688c2b3e6c1f,
               64'h1f83d9abfb41bd6b, 64'h5be0cd19137e2179};
      h384 = '{64'hcbbb9d5dc1059ed8, 64'h629a292a367cd507, 64'h9159015a3070dd17,
               64'h152fecd8f70e5939, 64'h67332667ffc00b31, 64'h8eb44a8768581511,
               64'hdb0c2e0d64f98fa7, 64'h47b5481dbefa4fa4};
      return mode ? h384[idx] : h512[idx];
   endfunction

   function automatic word_type rotr(input word_type x, input int unsigned n);
      return (x >> n) | (x << (64 - n));
   endfunction

endpackage

>>> hdl/sha512_round.sv
// one sha-512 round and message schedule step, shared over all 80 rounds
// depends on sha512_pkg
module sha512_round (
   input  sha512_pkg::word_type v_in [8],
   input  sha512_pkg::word_type sched [16],
   input  logic [6:0]           round,
   output sha512_pkg::word_type v_out [8],
   output sha512_pkg::word_type w_next
);
   import sha512_pkg::*;

   word_type w_cur, s0, s1, t1, t2, e, a;

   // current schedule word sits at the head of the window
   assign w_cur = sched[0];

   // next schedule word from the sliding window
   assign s0 = rotr(sched[1], 1) ^ rotr(sched[1], 8) ^ (sched[1] >> 7);
   assign s1 = rotr(sched[14], 19) ^ rotr(sched[14], 61) ^ (sched[14] >> 6);
   assign w_next = sched[0] + s0 + sched[9] + s1;

   // round function
   assign e = v_in[4];
   assign a = v_in[0];
   assign t1 = v_in[7] + (rotr(e, 14) ^ rotr(e, 18) ^ rotr(e, 41))
             + ((e & v_in[5]) ^ (~e & v_in[6])) + round_const(round) + w_cur;
   assign t2 = (rotr(a, 28) ^ rotr(a, 34) ^ rotr(a, 39))
             + ((a & v_in[1]) ^ (a & v_in[2]) ^ (v_in[1] & v_in[2]));

   always_comb begin
      v_out[7] = v_in[6];
      v_out[6] = v_in[5];
      v_out[5] = v_in[4];
      v_out[4] = v_in[3] + t1;
      v_out[3] = v_in[2];
      v_out[2] = v_in[1];
      v_out[1] = v_in[0];
      v_out[0] = t1 + t2;
   end

endmodule

>>> hdl/sha512_sha384_hash_core.sv
// sha-512 / sha-384 hash core, top level with sequencer and block buffer
// depends on sha512_pkg and sha512_round
//
// usage: message words arrive on req_ (tdata = 64-bit word, big-endian bytes,
// then 4-bit valid byte count; tlast marks the final word). every word except
// the last is full. digest words leave on rsp_ (tdata = 64-bit word then
// 3-bit index; tlast on the final word: index 7 for sha-512, 5 for sha-384).
// csr_ writes the mode bit (0 sha-512, 1 sha-384) and restarts the message.
// timing: a word that does not complete a block is only stored. the 16th
// word of a block starts the rounds and then the fold, one round per cycle
// in the shared round unit. the last word adds padding at one word per cycle
// and one or two compressions, then the digest words.
// req_tready is low while a compression, padding or digest output runs.
// a stalled rsp_tready holds the current digest word until taken.
// reset: synchronous, selects sha-512 and clears the length and fill count.
module sha512_sha384_hash_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [71:0] req_tdata,  // message_word[63:0], bytes_valid[67:64], zero pad
   input  logic        req_tlast,  // last_word
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [71:0] rsp_tdata,  // digest_word[63:0], word_index[66:64], zero pad
   output logic        rsp_tlast,  // digest_end
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic        csr_data    // digest_mode
);
   import sha512_pkg::*;

   state_type  state_ff, state_in;
   logic       mode_ff;
   word_type   chain_ff [8];
   word_type   v_ff [8];
   word_type   sched_ff [16];
   logic [3:0] fill_ff;
   word_type   bytes_ff;
   logic [6:0] round_ff;
   logic [2:0] out_ff;
   logic       last_ff;  // 0x80 word still to be pushed after a full last word
   logic       len_hi_ff; // next length word is high half
   logic       fin_ff;    // current message is in its final padding

   word_type   v_next [8];
   word_type   w_next;

   sha512_round u_round (
      .v_in  (v_ff),
      .sched (sched_ff),
      .round (round_ff),
      .v_out (v_next),
      .w_next(w_next)
   );

   logic       req_fire;
   logic [3:0] nb;
   word_type   word_in, mask, padded, push_w;
   logic       push;
   word_type   bytes_sum;

   assign req_fire  = req_tvalid && req_tready;
   assign req_tready = (state_ff == ST_IDLE);
   assign csr_ready = 1'b1;

   // saturate byte count and build masked padded word
   assign nb = req_tdata[67:64] > 4'd8 ? 4'd8 : req_tdata[67:64];
   assign word_in = req_tdata[63:0];
   assign mask = (nb == 4'd0) ? '0 : ~(64'hffffffffffffffff >> {nb[2:0], 3'b000});
   assign padded = (word_in & mask) | (64'h80 << (7'd56 - {nb[2:0], 3'b000}));
   assign bytes_sum = bytes_ff + (req_tlast ? {60'd0, nb} : 64'd8);

   // word pushed into the block buffer this cycle
   always_comb begin
      push = 1'b0;
      push_w = '0;
      case (state_ff)
         ST_IDLE: begin
            push = req_fire;
            push_w = (req_tlast && nb != 4'd8) ? padded : word_in;
         end
         ST_PAD: begin
            push = 1'b1;
            push_w = last_ff ? 64'h8000000000000000 : '0;
         end
         ST_LEN: begin
            push = 1'b1;
            push_w = len_hi_ff ? {61'd0, bytes_ff[63:61]} : {bytes_ff[60:0], 3'b000};
         end
         default: ;
      endcase
   end

   // sequencer next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE:
            if (req_fire) begin
               if (fill_ff == 4'd15) state_in = ST_ROUND;
               else if (req_tlast) state_in = (fill_ff == 4'd13 && nb != 4'd8) ? ST_LEN : ST_PAD;
            end
         ST_PAD:
            if (fill_ff == 4'd15) state_in = ST_ROUND;
            else if (fill_ff == LENGTH_SLOT - 4'd1) state_in = ST_LEN;
         ST_LEN:
            if (!len_hi_ff) state_in = ST_ROUND;
         ST_ROUND:
            if (round_ff == 7'(ROUNDS - 1)) state_in = ST_FOLD;
         ST_FOLD:
            if (!fin_ff) state_in = ST_IDLE;
            else if (len_hi_ff) state_in = ST_PAD; // more padding pending
            else state_in = ST_OUT;
         ST_OUT:
            if (rsp_tready && rsp_tlast) state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         mode_ff <= 1'b0;
         fill_ff <= '0;
         bytes_ff <= '0;
         round_ff <= '0;
         out_ff <= '0;
         last_ff <= 1'b0;
         len_hi_ff <= 1'b0;
         for (int i = 0; i < 8; i++) chain_ff[i] <= init_value(1'b0, 3'(i));
      end else if (csr_valid) begin
         state_ff <= ST_IDLE;
         mode_ff <= csr_data;
         fill_ff <= '0;
         bytes_ff <= '0;
         last_ff <= 1'b0;
         for (int i = 0; i < 8; i++) chain_ff[i] <= init_value(csr_data, 3'(i));
      end else begin
         state_ff <= state_in;
         if (push) fill_ff <= fill_ff + 4'd1;
         case (state_ff)
            ST_IDLE:
               if (req_fire) begin
                  bytes_ff <= bytes_sum;
                  // pending 0x80 word when the last word is full
                  last_ff <= req_tlast && nb == 4'd8;
                  len_hi_ff <= 1'b1;
                  if (req_tlast) out_ff <= '0;
               end
            ST_PAD: last_ff <= 1'b0;
            ST_LEN: len_hi_ff <= 1'b0;
            ST_FOLD: begin
               for (int i = 0; i < 8; i++) chain_ff[i] <= chain_ff[i] + v_ff[i];
            end
            ST_OUT:
               if (rsp_tready) begin
                  out_ff <= out_ff + 3'd1;
                  if (rsp_tlast) begin
                     fill_ff <= '0;
                     bytes_ff <= '0;
                     for (int i = 0; i < 8; i++) chain_ff[i] <= init_value(mode_ff, 3'(i));
                  end
               end
            default: ;
         endcase
         if (state_ff == ST_ROUND) round_ff <= round_ff + 7'd1;
         else round_ff <= '0;
      end
   end

   // track whether current message is finishing
   always_ff @(posedge clock) begin
      if (reset || csr_valid) fin_ff <= 1'b0;
      else if (state_ff == ST_IDLE && req_fire) fin_ff <= req_tlast;
      else if (state_ff == ST_OUT && rsp_tready && rsp_tlast) fin_ff <= 1'b0;
   end

   // block buffer and working variables: schedule window slides during rounds
   always_ff @(posedge clock) begin
      if (push) sched_ff[fill_ff] <= push_w;
      if (state_ff == ST_ROUND) begin
         for (int i = 0; i < 15; i++) sched_ff[i] <= sched_ff[i + 1];
         sched_ff[15] <= w_next;
         for (int i = 0; i < 8; i++) v_ff[i] <= v_next[i];
      end else begin
         for (int i = 0; i < 8; i++) v_ff[i] <= chain_ff[i];
      end
   end

   assign rsp_tvalid = (state_ff == ST_OUT);
   assign rsp_tdata  = {5'd0, out_ff, chain_ff[out_ff]};
   assign rsp_tlast  = mode_ff ? (out_ff == 3'd5) : (out_ff == 3'd7);

endmodule

>>> hdl/sha512_checker.sv
// port-level checker for the sha-512/384 core, bound to the top level
// depends on assert_macros.svh
`include "assert_macros.svh"
module sha512_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic        rsp_tlast,
   input logic [71:0] rsp_tdata
);
   // no request taken while a digest is shown
   `ASSERT_ALWAYS(a_excl, clock, reset, !(rsp_tvalid && req_tready), "ready during output")
   // digest word held while stalled
   `ASSERT_NEXT(a_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata), "output dropped")
   // final digest word index is 5 or 7
   `ASSERT_ALWAYS(a_end, clock, reset, !(rsp_tvalid && rsp_tlast) || rsp_tdata[66:64] == 3'd5 || rsp_tdata[66:64] == 3'd7, "bad end index")
endmodule

bind sha512_sha384_hash_core sha512_checker u_chk (
   .clock(clock), .reset(reset), .req_tvalid(req_tvalid), .req_tready(req_tready),
   .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tlast(rsp_tlast),
   .rsp_tdata(rsp_tdata)
);

>>> verif/sha512_sha384_hash_core_test.sv
// testbench for the sha-512/384 hash core: directed table then random messages,
// each digest checked against a behavioral model of the compression and padding
// depends on sha512_pkg and sha512_sha384_hash_core
module sha512_sha384_hash_core_test;
   timeunit 1ns;
   timeprecision 1ps;
   import sha512_pkg::*;

   localparam int IDLE_MAX = 13;
   localparam int STALL_LIMIT = 20000;

   typedef struct packed {
      logic [63:0] word;
      logic [2:0]  index;
      logic        last;
   } digest_item_type;

   typedef struct {
      logic [63:0] word;
      logic [3:0]  nbytes;
      logic        last;
      logic        check_known;
      logic [63:0] known_first;
   } msg_row_type;

   logic        clock = 0;
   logic        reset = 1;
   logic        req_tvalid = 0;
   logic        req_tready;
   logic [71:0] req_tdata = '0;
   logic        req_tlast = 0;
   logic        rsp_tvalid;
   logic        rsp_tready = 0;
   logic [71:0] rsp_tdata;
   logic        rsp_tlast;
   logic        csr_valid = 0;
   logic        csr_ready;
   logic        csr_data = 0;

   sha512_sha384_hash_core u_dut (.*);

   always #2 clock = ~clock;

   // model state of the hash
   logic        mode_q;
   logic [63:0] chain_q [8];
   logic [63:0] blk_q [16];
   int          fill_q;
   logic [63:0] total_q;

   digest_item_type digest_queue [$];
   logic [63:0]  known_first_queue [$];
   logic         known_valid_queue [$];
   int  error_count = 0;
   int  idle_cycles = 0;
   int  holdoff = 0;
   bit  stim_done = 0;

   localparam logic [63:0] ABC_512_FIRST = 64'hddaf35a193617aba;
   localparam logic [63:0] EMPTY_512_FIRST = 64'hcf83e1357eefb8bd;
   localparam logic [63:0] EMPTY_384_FIRST = 64'h38b060a751ac9638;

   function automatic logic [63:0] ror64(logic [63:0] x, int n);
      return (x >> n) | (x << (64 - n));
   endfunction

   function automatic logic [63:0] iv_word(logic m, int i);
      logic [63:0] h512 [8];
      logic [63:0] h384 [8];
      h512 = '{64'h6a09e667f3bcc908, 64'hbb67ae8584caa73b, 64'h3c6ef372fe94f82b,
               64'ha54ff53a5f1d36f1, 64'h510e527fade682d1, 64'h9b05688c2b3e6c1f,
               64'h1f83d9abfb41bd6b, 64'h5be0cd19137e2179};
      h384 = '{64'hcbbb9d5dc1059ed8, 64'h629a292a367cd507, 64'h9159015a3070dd17,
               64'h152fecd8f70e5939, 64'h67332667ffc00b31, 64'h8eb44a8768581511,
               64'hdb0c2e0d64f98fa7, 64'h47b5481dbefa4fa4};
      return m ? h384[i] : h512[i];
   endfunction

   function automatic logic [63:0] k_word(int i);
      logic [63:0] k [80];
      k = '{
         64'h428a2f98d728ae22, 64'h7137449123ef65cd, 64'hb5c0fbcfec4d3b2f, 64'he9b5dba58189dbbc,
         64'h3956c25bf348b538, 64'h59f111f1b605d019, 64'h923f82a4af194f9b, 64'hab1c5ed5da6d8118,
         64'hd807aa98a3030242, 64'h12835b0145706fbe, 64'h243185be4ee4b28c, 64'h550c7dc3d5ffb4e2,
         64'h72be5d74f27b896f, 64'h80deb1fe3b1696b1, 64'h9bdc06a725c71235, 64'hc19bf174cf692694,
         64'he49b69c19ef14ad2, 64'hefbe4786384f25e3, 64'h0fc19dc68b8cd5b5, 64'h240ca1cc77ac9c65,
         64'h2de92c6f592b0275, 64'h4a7484aa6ea6e483, 64'h5cb0a9dcbd41fbd4, 64'h76f988da831153b5,
         64'h983e5152ee66dfab, 64'ha831c66d2db43210, 64'hb00327c898fb213f, 64'hbf597fc7beef0ee4,
         64'hc6e00bf33da88fc2, 64'hd5a79147930aa725, 64'h06ca6351e003826f, 64'h142929670a0e6e70,
         64'h27b70a8546d22ffc, 64'h2e1b21385c26c926, 64'h4d2c6dfc5ac42aed, 64'h53380d139d95b3df,
         64'h650a73548baf63de, 64'h766a0abb3c77b2a8, 64'h81c2c92e47edaee6, 64'h92722c851482353b,
         64'ha2bfe8a14cf10364, 64'ha81a664bbc423001, 64'hc24b8b70d0f89791, 64'hc76c51a30654be30,
         64'hd192e819d6ef5218, 64'hd69906245565a910, 64'hf40e35855771202a, 64'h106aa07032bbd1b8,
         64'h19a4c116b8d2d0c8, 64'h1e376c085141ab53, 64'h2748774cdf8eeb99, 64'h34b0bcb5e19b48a8,
         64'h391c0cb3c5c95a63, 64'h4ed8aa4ae3418acb, 64'h5b9cca4f7763e373, 64'h682e6ff3d6b2b8a3,
         64'h748f82ee5defb2fc, 64'h78a5636f43172f60, 64'h84c87814a1f0ab72, 64'h8cc702081a6439ec,
         64'h90befffa23631e28, 64'ha4506cebde82bde9, 64'hbef9a3f7b2c67915, 64'hc67178f2e372532b,
         64'hca273eceea26619c, 64'hd186b8c721c0c207, 64'heada7dd6cde0eb1e, 64'hf57d4f7fee6ed178,
         64'h06f067aa72176fba, 64'h0a637dc5a2c898a6, 64'h113f9804bef90dae, 64'h1b710b35131c471b,
         64'h28db77f523047d84, 64'h32caab7b40c72493, 64'h3c9ebe0a15c9bebc, 64'h431d67c49c100d4c,
         64'h4cc5d4becb3e42b6, 64'h597f299cfc657e2a, 64'h5fcb6fab3ad6faec, 64'h6c44198c4a475817};
      return k[i];
   endfunction

   function automatic void restart_message();
      for (int i = 0; i < 8; i++) chain_q[i] = iv_word(mode_q, i);
      fill_q = 0;
      total_q = '0;
   endfunction

   // one 80-round compression of the buffered block
   function automatic void compress_block();
      logic [63:0] w [80];
      logic [63:0] v [8];
      logic [63:0] s0, s1, t1, t2;
      for (int i = 0; i < 16; i++) w[i] = blk_q[i];
      for (int i = 16; i < 80; i++) begin
         s0 = ror64(w[i-15], 1) ^ ror64(w[i-15], 8) ^ (w[i-15] >> 7);
         s1 = ror64(w[i-2], 19) ^ ror64(w[i-2], 61) ^ (w[i-2] >> 6);
         w[i] = w[i-16] + s0 + w[i-7] + s1;
      end
      for (int i = 0; i < 8; i++) v[i] = chain_q[i];
      for (int i = 0; i < 80; i++) begin
         t1 = v[7] + (ror64(v[4], 14) ^ ror64(v[4], 18) ^ ror64(v[4], 41))
            + ((v[4] & v[5]) ^ (~v[4] & v[6])) + k_word(i) + w[i];
         t2 = (ror64(v[0], 28) ^ ror64(v[0], 34) ^ ror64(v[0], 39))
            + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
         v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
         v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
      end
      for (int i = 0; i < 8; i++) chain_q[i] += v[i];
   endfunction

   function automatic void append_word(logic [63:0] w);
      blk_q[fill_q] = w;
      fill_q++;
      if (fill_q == 16) begin
         compress_block();
         fill_q = 0;
      end
   endfunction

   // model one accepted request; queues the digest on a last word
   function automatic void predict_word(logic [63:0] w, logic [3:0] nb, logic last);
      int n;
      int count;
      logic [63:0] mask;
      digest_item_type d;
      if (!last) begin
         total_q += 8;
         append_word(w);
         return;
      end
      n = (nb > 8) ? 8 : nb;
      total_q += n;
      if (n == 8) begin
         append_word(w);
         append_word(64'h8000000000000000);
      end else begin
         mask = (n == 0) ? '0 : ~64'h0 << (64 - 8 * n);
         append_word((w & mask) | (64'h80 << (56 - 8 * n)));
      end
      while (fill_q != 14) append_word('0);
      append_word(total_q >> 61);
      append_word(total_q << 3);
      count = mode_q ? 6 : 8;
      for (int k = 0; k < count; k++) begin
         d.word = chain_q[k];
         d.index = k[2:0];
         d.last = (k + 1 == count);
         digest_queue.push_back(d);
      end
      restart_message();
   endfunction

   task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
      $display("mismatch %s: got %h expected %h at %0t", what, got, want, $realtime);
      error_count++;
   endtask

   // receiver: random stall per digest word, plus a long hold-off on request
   initial begin
      int gap;
      @(negedge clock);
      forever begin
         if (holdoff > 0) begin
            rsp_tready <= 0;
            holdoff--;
            @(negedge clock);
         end else begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, IDLE_MAX);
            rsp_tready <= 0;
            repeat (gap) @(negedge clock);
            rsp_tready <= 1;
            @(posedge clock);
            while (!(rsp_tvalid && rsp_tready)) @(posedge clock);
            @(negedge clock);
         end
      end
   end

   // checker on the result channel
   always @(posedge clock) begin
      digest_item_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (digest_queue.size() == 0) begin
            report_mismatch("unexpected digest word", rsp_tdata[63:0], '0);
         end else begin
            want = digest_queue.pop_front();
            if (rsp_tdata[63:0] !== want.word)
               report_mismatch("digest_word", rsp_tdata[63:0], want.word);
            if (rsp_tdata[66:64] !== want.index)
               report_mismatch("word_index", 64'(rsp_tdata[66:64]), 64'(want.index));
            if (rsp_tlast !== want.last)
               report_mismatch("digest_end", 64'(rsp_tlast), 64'(want.last));
            if (want.index == 0 && known_valid_queue.size() > 0) begin
               if (known_valid_queue.pop_front() && rsp_tdata[63:0] !== known_first_queue[0])
                  report_mismatch("known digest", rsp_tdata[63:0], known_first_queue[0]);
               void'(known_first_queue.pop_front());
            end
         end
      end
   end

   // watchdog on cycles without any handshake
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || (csr_valid && csr_ready)
          || holdoff > 0)
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles > STALL_LIMIT) begin
         $display("*** FAILED ***");
         $finish;
      end
   end

   task automatic send_word(logic [63:0] w, logic [3:0] nb, logic last, bit idle_ok,
                            bit has_known, logic [63:0] known);
      if (idle_ok && $urandom_range(0, 2) != 0) begin
         req_tvalid <= 0;
         repeat ($urandom_range(0, IDLE_MAX)) @(negedge clock);
      end
      req_tvalid <= 1;
      req_tdata <= {4'b0, nb, w};
      req_tlast <= last;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      predict_word(w, nb, last);
      if (last) begin
         known_valid_queue.push_back(has_known);
         known_first_queue.push_back(known);
      end
      @(negedge clock);
   endtask

   task automatic wait_drained();
      req_tvalid <= 0;
      while (digest_queue.size() != 0) @(negedge clock);
      repeat (200) @(negedge clock);
   endtask

   task automatic write_mode(logic m);
      csr_valid <= 1;
      csr_data <= m;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      mode_q = m;
      restart_message();
      @(negedge clock);
      csr_valid <= 0;
   endtask

   // random message; most are short, some span two blocks
   task automatic send_message(int nwords, bit idle_ok);
      logic [63:0] w;
      for (int i = 0; i < nwords; i++) begin
         w = {$urandom, $urandom};
         if (i == nwords - 1)
            send_word(w, 4'($urandom_range(0, 15)), 1, idle_ok, 0, '0);
         else
            send_word(w, 4'($urandom_range(0, 15)), 0, idle_ok, 0, '0);
      end
   endtask

   initial begin
      msg_row_type rows [$];
      int msg_words;
      int sent;
      mode_q = 0;
      restart_message();
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 0;

      // directed table: known vectors, byte-count extremes, padding boundaries
      rows.push_back('{64'h0, 4'd0, 1, 1, EMPTY_512_FIRST});
      rows.push_back('{64'h6162630000000000, 4'd3, 1, 1, ABC_512_FIRST});
      rows.push_back('{64'hffffffffffffffff, 4'd8, 1, 0, '0});
      rows.push_back('{64'hffffffffffffffff, 4'd15, 1, 0, '0});
      rows.push_back('{64'hffffffffffffffff, 4'd7, 1, 0, '0});
      rows.push_back('{64'h0123456789abcdef, 4'd1, 1, 0, '0});
      foreach (rows[i])
         send_word(rows[i].word, rows[i].nbytes, rows[i].last, 0, rows[i].check_known,
                   rows[i].known_first);
      // fourteen full words then a full last word: length spills to a second block
      for (int i = 0; i < 14; i++) send_word(~64'h0, 4'd15, 0, 0, 0, '0);
      send_word(64'h0, 4'd8, 1, 0, 0, '0);
      wait_drained();

      write_mode(1);
      send_word(64'h0, 4'd0, 1, 0, 1, EMPTY_384_FIRST);
      send_message(16, 0);
      wait_drained();

      // partial message discarded by a mode write
      send_word(64'h1111, 4'd8, 0, 0, 0, '0);
      send_word(64'h2222, 4'd8, 0, 0, 0, '0);
      repeat (50) @(negedge clock);
      write_mode(0);

      // long receiver hold-off while the sender keeps offering
      holdoff = 600;
      for (int i = 0; i < 3; i++) send_message(1, 0);
      wait_drained();

      sent = 0;
      for (int phase = 0; phase < 4; phase++) begin
         write_mode(phase[0]);
         while (sent < (phase + 1) * 30) begin
            msg_words = ($urandom_range(0, 9) == 0) ? 17 : $urandom_range(1, 6);
            send_message(msg_words, phase != 2);
            sent += msg_words;
         end
         wait_drained();
      end

      req_tvalid <= 0;
      wait_drained();
      if (error_count == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end
endmodule

>>> files.f
+incdir+hdl
hdl/sha512_pkg.sv
hdl/sha512_round.sv
hdl/sha512_sha384_hash_core.sv
hdl/sha512_checker.sv
verif/sha512_sha384_hash_core_test.sv
